// ----- src/gmsf_pkg.sv -----
package gmsf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int DIM_W   = 7;
  localparam int COLOR_W = 8;
  localparam int PIX_W   = 3 * COLOR_W;
  localparam int E_W     = 19;
  localparam int TOTAL_W = 25;
  localparam int POS_W   = 6;
  localparam int IDX_W   = 2;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LC_W   = $clog2(DEPTH + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
  localparam logic [DIM_W-1:0]   DIM_MIN      = DIM_W'(3);
  localparam logic [DIM_W-1:0]   WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]   HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(64);
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(64);

  typedef enum logic [IDX_W-1:0] {
    REG_DIRECTION    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [5:0]         seam_position;
    logic [TOTAL_W-1:0] seam_total;
    logic               last;
  } seam_t;

  typedef struct packed {
    logic             vert;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } frame_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x);
  endfunction

  // Sum of squared per-channel differences of two packed pixels.
  function automatic logic [E_W-1:0] sq_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic signed [COLOR_W:0]     d;
    logic signed [2*COLOR_W+1:0] dd;
    logic [E_W-1:0]              s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d  = $signed({1'b0, a[k*COLOR_W +: COLOR_W]}) - $signed({1'b0, b[k*COLOR_W +: COLOR_W]});
      dd = d * d;
      s  = s + E_W'(dd);
    end
    return s;
  endfunction

endpackage

// ----- src/gmsf_ram.sv -----
module gmsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/gmsf_energy.sv -----
module gmsf_energy import gmsf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  frame_t            frame_i,
  output logic [ADDR_W-1:0] pix_raddr_o,
  input  logic [PIX_W-1:0]  pix_rdata_i,
  output logic              e_we_o,
  output logic [ADDR_W-1:0] e_waddr_o,
  output logic [E_W-1:0]    e_wdata_o,
  output logic              done_o
);

  typedef enum logic [2:0] {E_IDLE, E_XR, E_XL, E_YD, E_YU, E_WR} state_e;

  state_e           state_q;
  logic [POS_W-1:0] x_q, y_q;
  logic [PIX_W-1:0] a_q;
  logic [E_W-1:0]   e1_q;
  logic             done_q;

  logic [POS_W-1:0] wm1, hm1, xl, xr, yu, yd;

  always_comb begin
    wm1 = POS_W'(frame_i.width - DIM_W'(1));
    hm1 = POS_W'(frame_i.height - DIM_W'(1));
    xl  = (x_q == '0) ? wm1 : x_q - POS_W'(1);
    xr  = (x_q == wm1) ? '0 : x_q + POS_W'(1);
    yu  = (y_q == '0) ? hm1 : y_q - POS_W'(1);
    yd  = (y_q == hm1) ? '0 : y_q + POS_W'(1);
  end

  always_comb begin
    case (state_q)
      E_XR:    pix_raddr_o = pix_addr(xr, y_q);
      E_XL:    pix_raddr_o = pix_addr(xl, y_q);
      E_YD:    pix_raddr_o = pix_addr(x_q, yd);
      default: pix_raddr_o = pix_addr(x_q, yu);
    endcase
  end

  assign e_we_o    = (state_q == E_WR);
  assign e_waddr_o = pix_addr(x_q, y_q);
  assign e_wdata_o = e1_q + sq_diff(a_q, pix_rdata_i);
  assign done_o    = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == E_WR) && (x_q == wm1) && (y_q == hm1);
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            x_q     <= '0;
            y_q     <= '0;
            state_q <= E_XR;
          end
        end
        E_XR: state_q <= E_XL;
        E_XL: begin
          a_q     <= pix_rdata_i;
          state_q <= E_YD;
        end
        E_YD: begin
          e1_q    <= sq_diff(a_q, pix_rdata_i);
          state_q <= E_YU;
        end
        E_YU: begin
          a_q     <= pix_rdata_i;
          state_q <= E_WR;
        end
        E_WR: begin
          if (x_q == wm1) begin
            x_q <= '0;
            if (y_q == hm1) begin
              state_q <= E_IDLE;
            end else begin
              y_q     <= y_q + POS_W'(1);
              state_q <= E_XR;
            end
          end else begin
            x_q     <= x_q + POS_W'(1);
            state_q <= E_XR;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

endmodule

// ----- src/gmsf_walker.sv -----
module gmsf_walker import gmsf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  frame_t            frame_i,
  output logic [ADDR_W-1:0] e_raddr_o,
  input  logic [E_W-1:0]    e_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output seam_t             out_data_o,
  output logic              done_o
);

  typedef enum logic [2:0] {W_IDLE, W_MID, W_LO, W_HI, W_PICK} state_e;

  state_e             state_q;
  logic               emit_q;
  logic [POS_W-1:0]   s_q, pos_q, i_q, best_start_q;
  logic [TOTAL_W-1:0] total_q, best_total_q;
  logic [E_W-1:0]     m_q, l_q;
  logic               out_valid_q;
  seam_t              out_q;
  logic               done_q;

  logic [POS_W-1:0]   lenm1, spanm1, pos_lo, pos_hi, across, next_pos;
  logic               has_lo, has_hi, go_lo, stay, better, load_out;
  logic [E_W-1:0]     hv, pick;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sum_sat;

  always_comb begin
    lenm1  = frame_i.vert ? POS_W'(frame_i.height - DIM_W'(1))
                          : POS_W'(frame_i.width - DIM_W'(1));
    spanm1 = frame_i.vert ? POS_W'(frame_i.width - DIM_W'(1))
                          : POS_W'(frame_i.height - DIM_W'(1));
    pos_lo = pos_q - POS_W'(1);
    pos_hi = pos_q + POS_W'(1);
    // The first step of a walk has no choice, so both neighbors read as the middle.
    has_lo = (pos_q != '0) && (i_q != '0);
    has_hi = (pos_q != spanm1) && (i_q != '0);

    case (state_q)
      W_MID:   across = pos_q;
      W_LO:    across = pos_lo;
      default: across = pos_hi;
    endcase
    e_raddr_o = frame_i.vert ? pix_addr(across, i_q) : pix_addr(i_q, across);

    hv = has_hi ? e_rdata_i : m_q;
    if (frame_i.vert) go_lo = (l_q < m_q) && (l_q < hv);
    else              go_lo = (l_q < m_q) && (l_q <= hv);
    stay = (m_q <= l_q) && (m_q <= hv);
    if (go_lo) begin
      pick     = l_q;
      next_pos = pos_lo;
    end else if (stay) begin
      pick     = m_q;
      next_pos = pos_q;
    end else begin
      pick     = hv;
      next_pos = pos_hi;
    end
    sum     = {1'b0, total_q} + (TOTAL_W + 1)'(pick);
    sum_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    better  = (s_q == '0) || (sum_sat < best_total_q);
    load_out = (state_q == W_PICK) && emit_q && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign done_o      = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= W_IDLE;
      emit_q       <= 1'b0;
      s_q          <= '0;
      pos_q        <= '0;
      i_q          <= '0;
      total_q      <= '0;
      best_start_q <= '0;
      best_total_q <= '0;
      out_valid_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      done_q <= load_out && (i_q == lenm1);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        W_IDLE: begin
          if (start_i) begin
            emit_q  <= 1'b0;
            s_q     <= '0;
            pos_q   <= '0;
            i_q     <= '0;
            total_q <= '0;
            state_q <= W_MID;
          end
        end
        W_MID: state_q <= W_LO;
        W_LO: begin
          m_q     <= e_rdata_i;
          state_q <= W_HI;
        end
        W_HI: begin
          l_q     <= has_lo ? e_rdata_i : m_q;
          state_q <= W_PICK;
        end
        W_PICK: begin
          if (emit_q) begin
            // The winning walk is replayed here, one result per step.
            if (load_out) begin
              out_q.seam_position <= 6'(next_pos);
              out_q.seam_total    <= best_total_q;
              out_q.last          <= (i_q == lenm1);
              pos_q               <= next_pos;
              if (i_q == lenm1) begin
                state_q <= W_IDLE;
              end else begin
                i_q     <= i_q + POS_W'(1);
                state_q <= W_MID;
              end
            end
          end else begin
            state_q <= W_MID;
            if (i_q == lenm1) begin
              i_q     <= '0;
              total_q <= '0;
              if (better) begin
                best_total_q <= sum_sat;
                best_start_q <= s_q;
              end
              if (s_q == spanm1) begin
                emit_q <= 1'b1;
                pos_q  <= better ? s_q : best_start_q;
              end else begin
                s_q   <= s_q + POS_W'(1);
                pos_q <= s_q + POS_W'(1);
              end
            end else begin
              pos_q   <= next_pos;
              total_q <= sum_sat;
              i_q     <= i_q + POS_W'(1);
            end
          end
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

endmodule

// ----- src/greedy_min_seam_finder.sv -----
// Greedy minimum-seam finder. Pixels arrive row-major, one transfer per cycle while
// in_ready_o is high, until frame_width x frame_height have been taken; the pixel that
// completes the frame starts an energy pass over the pixel memory (its single read port
// serves four neighbor reads and a write per pixel) and then a greedy walk from every start
// column or row through the energy memory (three neighbor reads and a decision per step);
// the winning seam is then replayed as len results, one per step as out_ready_i allows. No
// pixel is taken during that time. After any configuration write the block recomputes its
// load position by restoring division before it takes pixels.
module greedy_min_seam_finder import gmsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pixel_t           in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output seam_t            out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i
);

  localparam int DCNT_W = $clog2(LC_W + 1);

  logic             direction_q;
  logic [DIM_W-1:0] frame_width_q, frame_height_q;
  logic [LC_W-1:0]  load_count_q, row_q, div_q;
  logic [POS_W-1:0] col_q;
  logic [DIM_W-1:0] rem_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic             busy_q;

  frame_t           frame;
  logic             in_fire, cfg_fire, frame_done, pix_we;
  logic [LC_W-1:0]  area;
  logic [LC_W:0]    count_next;
  logic [POS_W-1:0] wm1;
  logic [DIM_W:0]   trial;
  logic             qbit;
  logic [DIM_W-1:0] rem_next;
  logic [LC_W-1:0]  div_next;

  logic [ADDR_W-1:0] pix_raddr, e_raddr, e_waddr;
  logic [PIX_W-1:0]  pix_rdata;
  logic              e_we, energy_done, walk_done;
  logic [E_W-1:0]    e_wdata, e_rdata;

  always_comb begin
    frame.vert   = !direction_q;
    frame.width  = clamp_dim(frame_width_q, WIDTH_LIMIT);
    frame.height = clamp_dim(frame_height_q, HEIGHT_LIMIT);
    area         = LC_W'(frame.width * frame.height);
    wm1          = POS_W'(frame.width - DIM_W'(1));
    in_ready_o   = !busy_q && (div_cnt_q == '0);
    in_fire      = in_valid_i && in_ready_o;
    cfg_ready_o  = 1'b1;
    cfg_fire     = cfg_valid_i;
    count_next   = {1'b0, load_count_q} + (LC_W + 1)'(1);
    frame_done   = in_fire && (count_next >= (LC_W + 1)'(area));
    pix_we       = in_fire && (row_q < LC_W'(frame.height));

    // One restoring division step: row and column of the load count for the new width.
    trial    = {rem_q, div_q[LC_W-1]};
    qbit     = (trial >= (DIM_W + 1)'(frame.width));
    rem_next = qbit ? DIM_W'(trial - (DIM_W + 1)'(frame.width)) : DIM_W'(trial);
    div_next = {div_q[LC_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q    <= 1'b0;
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      load_count_q   <= '0;
      row_q          <= '0;
      col_q          <= '0;
      div_q          <= '0;
      rem_q          <= '0;
      div_cnt_q      <= '0;
      busy_q         <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index_i)
          REG_DIRECTION:    direction_q    <= cfg_data_i[0];
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
        div_q     <= load_count_q;
        rem_q     <= '0;
        div_cnt_q <= DCNT_W'(LC_W);
      end else if (div_cnt_q != '0) begin
        div_q     <= div_next;
        rem_q     <= rem_next;
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
        if (div_cnt_q == DCNT_W'(1)) begin
          row_q <= div_next;
          col_q <= POS_W'(rem_next);
        end
      end

      if (in_fire) begin
        if (frame_done) begin
          load_count_q <= '0;
          row_q        <= '0;
          col_q        <= '0;
          busy_q       <= 1'b1;
        end else begin
          load_count_q <= count_next[LC_W-1:0];
          if (col_q == wm1) begin
            col_q <= '0;
            row_q <= row_q + LC_W'(1);
          end else begin
            col_q <= col_q + POS_W'(1);
          end
        end
      end else if (walk_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  gmsf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_addr(col_q, POS_W'(row_q))),
    .wdata_i ({in_data_i.blue, in_data_i.green, in_data_i.red}),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  gmsf_ram #(
    .WIDTH (E_W),
    .DEPTH (DEPTH)
  ) u_energy_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  gmsf_energy u_energy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (frame_done),
    .frame_i     (frame),
    .pix_raddr_o (pix_raddr),
    .pix_rdata_i (pix_rdata),
    .e_we_o      (e_we),
    .e_waddr_o   (e_waddr),
    .e_wdata_o   (e_wdata),
    .done_o      (energy_done)
  );

  gmsf_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (energy_done),
    .frame_i     (frame),
    .e_raddr_o   (e_raddr),
    .e_rdata_i   (e_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .done_o      (walk_done)
  );

endmodule
